// ===== rtl/jpi_pkg.sv =====
// Shared constants and types for the Jones product inverse block.
package jpi_pkg;
   // Default width of one real or imaginary part
   localparam int DEFAULT_PART_WIDTH = 32;
   // Packed complex word layout
   localparam int WORD_WIDTH = 64;
   localparam int REAL_LSB   = 32;
   localparam int IMAG_LSB   = 0;
   // Four complex elements, eight parts: even index real, odd index imaginary
   localparam int NUM_ELEMS  = 4;
   localparam int NUM_PARTS  = 8;

   // Status that travels with a word down the pipeline
   typedef struct packed {
      logic valid;
      logic all_zero;
      logic sat;
   } flags_type;
endpackage

// ===== rtl/jpi_product.sv =====
// Complex 2x2 product J = D*B with rounding and clipping of each part.
module jpi_product #(
   parameter int PART_WIDTH = jpi_pkg::DEFAULT_PART_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic signed [PART_WIDTH-1:0] d_part [jpi_pkg::NUM_PARTS],
   input  logic signed [PART_WIDTH-1:0] b_part [jpi_pkg::NUM_PARTS],
   output logic signed [PART_WIDTH-1:0] j_part [jpi_pkg::NUM_PARTS],
   output jpi_pkg::flags_type           j_flags
);
   import jpi_pkg::*;

   localparam int FB = PART_WIDTH / 2;
   localparam int PW = 2 * PART_WIDTH;
   localparam int SW = 2 * PART_WIDTH + 2;

   logic signed [PW-1:0]         prod_in [NUM_ELEMS][8];
   logic signed [PW-1:0]         prod_ff [NUM_ELEMS][8];
   logic                         valid_ff;
   logic signed [PART_WIDTH-1:0] j_in [NUM_PARTS];
   logic signed [PART_WIDTH-1:0] j_ff [NUM_PARTS];
   flags_type                    flags_in;
   flags_type                    flags_ff;

   // Stage 1: all partial products of every element
   always_comb begin
      for (int r = 0; r < 2; r++) begin
         for (int c = 0; c < 2; c++) begin
            prod_in[2*r+c][0] = d_part[4*r]   * b_part[2*c];
            prod_in[2*r+c][1] = d_part[4*r+1] * b_part[2*c+1];
            prod_in[2*r+c][2] = d_part[4*r+2] * b_part[4+2*c];
            prod_in[2*r+c][3] = d_part[4*r+3] * b_part[5+2*c];
            prod_in[2*r+c][4] = d_part[4*r]   * b_part[2*c+1];
            prod_in[2*r+c][5] = d_part[4*r+1] * b_part[2*c];
            prod_in[2*r+c][6] = d_part[4*r+2] * b_part[5+2*c];
            prod_in[2*r+c][7] = d_part[4*r+3] * b_part[4+2*c];
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   // Stage 2: sum, round half away from zero, clip
   always_comb begin
      logic signed [SW-1:0] t [8];
      logic signed [SW-1:0] acc [2];
      logic [SW-1:0]        mag;
      logic [SW-1:0]        rnd;
      logic [SW-1:0]        lim;
      logic                 neg;
      flags_in.valid    = valid_ff;
      flags_in.sat      = 1'b0;
      flags_in.all_zero = 1'b1;
      for (int e = 0; e < NUM_ELEMS; e++) begin
         for (int k = 0; k < 8; k++) begin
            t[k] = prod_ff[e][k];
         end
         acc[0] = t[0] - t[1] + t[2] - t[3];
         acc[1] = t[4] + t[5] + t[6] + t[7];
         for (int h = 0; h < 2; h++) begin
            neg = acc[h][SW-1];
            mag = neg ? SW'(-acc[h]) : SW'(acc[h]);
            rnd = (mag + (SW'(1) << (FB - 1))) >> FB;
            lim = neg ? (SW'(1) << (PART_WIDTH - 1))
                      : (SW'(1) << (PART_WIDTH - 1)) - SW'(1);
            if (rnd > lim) begin
               rnd          = lim;
               flags_in.sat = 1'b1;
            end
            j_in[2*e+h] = neg ? -rnd[PART_WIDTH-1:0] : rnd[PART_WIDTH-1:0];
            if (j_in[2*e+h] != '0) begin
               flags_in.all_zero = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      j_ff <= j_in;
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   assign j_part  = j_ff;
   assign j_flags = flags_ff;
endmodule

// ===== rtl/jpi_norm.sv =====
// Frobenius norm of J: sum of squares, then a bit-per-stage square root.
module jpi_norm #(
   parameter int PART_WIDTH = jpi_pkg::DEFAULT_PART_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic signed [PART_WIDTH-1:0] j_part [jpi_pkg::NUM_PARTS],
   input  jpi_pkg::flags_type           in_flags,
   output logic        [PART_WIDTH:0]   norm,
   output logic signed [PART_WIDTH-1:0] j_out [jpi_pkg::NUM_PARTS],
   output jpi_pkg::flags_type           out_flags
);
   import jpi_pkg::*;

   localparam int NW = 2 * PART_WIDTH + 2;
   localparam int RW = PART_WIDTH + 4;
   localparam int NS = PART_WIDTH + 2;

   logic [2*PART_WIDTH-1:0]      sq_in [NUM_PARTS];
   logic [2*PART_WIDTH-1:0]      sq_ff [NUM_PARTS];
   logic signed [PART_WIDTH-1:0] ja_ff [NUM_PARTS];
   flags_type                    fa_ff;
   logic [NW-1:0]                sum_in;

   logic [NW-1:0]                n_ff    [NS];
   logic [RW-1:0]                rem_ff  [NS];
   logic [PART_WIDTH:0]          root_ff [NS];
   logic signed [PART_WIDTH-1:0] jd_ff   [NS][NUM_PARTS];
   flags_type                    fd_ff   [NS];

   // Squares of the part magnitudes
   always_comb begin
      logic [PART_WIDTH-1:0] mg;
      for (int k = 0; k < NUM_PARTS; k++) begin
         mg       = j_part[k][PART_WIDTH-1] ? PART_WIDTH'(-j_part[k]) : PART_WIDTH'(j_part[k]);
         sq_in[k] = mg * mg;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff <= sq_in;
      ja_ff <= j_part;
      if (reset) begin
         fa_ff <= '0;
      end else begin
         fa_ff <= in_flags;
      end
   end

   // Sum of squares
   always_comb begin
      sum_in = '0;
      for (int k = 0; k < NUM_PARTS; k++) begin
         sum_in = sum_in + NW'(sq_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      n_ff[0]    <= sum_in;
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
      jd_ff[0]   <= ja_ff;
      if (reset) begin
         fd_ff[0] <= '0;
      end else begin
         fd_ff[0] <= fa_ff;
      end
   end

   // One root bit per stage, two radicand bits consumed each time
   for (genvar s = 0; s < NS - 1; s++) begin : g_sqrt
      logic [RW-1:0]       cur;
      logic [RW-1:0]       trial;
      logic [RW-1:0]       rem_in;
      logic [PART_WIDTH:0] root_in;

      always_comb begin
         cur   = {rem_ff[s][RW-3:0], n_ff[s][2*(PART_WIDTH-s) +: 2]};
         trial = RW'({root_ff[s], 2'b01});
         if (cur >= trial) begin
            rem_in  = cur - trial;
            root_in = {root_ff[s][PART_WIDTH-1:0], 1'b1};
         end else begin
            rem_in  = cur;
            root_in = {root_ff[s][PART_WIDTH-1:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         n_ff[s+1]    <= n_ff[s];
         rem_ff[s+1]  <= rem_in;
         root_ff[s+1] <= root_in;
         jd_ff[s+1]   <= jd_ff[s];
         if (reset) begin
            fd_ff[s+1] <= '0;
         end else begin
            fd_ff[s+1] <= fd_ff[s];
         end
      end
   end

   assign norm      = root_ff[NS-1];
   assign j_out     = jd_ff[NS-1];
   assign out_flags = fd_ff[NS-1];
endmodule

// ===== rtl/jpi_scale_lane.sv =====
// One lane of the norm scaling: rounded part * 2^FB / norm, restoring divide.
module jpi_scale_lane #(
   parameter int PART_WIDTH = jpi_pkg::DEFAULT_PART_WIDTH
) (
   input  logic                             clock,
   input  logic signed [PART_WIDTH-1:0]     part,
   input  logic        [PART_WIDTH:0]       norm,
   output logic signed [PART_WIDTH/2+1:0]   scaled
);
   localparam int FB = PART_WIDTH / 2;
   localparam int RW = PART_WIDTH + FB + 2;
   localparam int NS = FB + 2;

   logic [RW-1:0]       r_ff   [NS];
   logic [PART_WIDTH:0] f_ff   [NS];
   logic [FB:0]         q_ff   [NS];
   logic                neg_ff [NS];
   logic [PART_WIDTH-1:0] mag;

   // Setup: magnitude with rounding offset
   assign mag = part[PART_WIDTH-1] ? PART_WIDTH'(-part) : PART_WIDTH'(part);

   always_ff @(posedge clock) begin
      r_ff[0]   <= (RW'(mag) << FB) + RW'(norm >> 1);
      f_ff[0]   <= norm;
      q_ff[0]   <= '0;
      neg_ff[0] <= part[PART_WIDTH-1];
   end

   // One quotient bit per stage, most significant first
   for (genvar t = 0; t <= FB; t++) begin : g_div
      logic [RW-1:0] dsh;
      logic          ge;

      assign dsh = RW'(f_ff[t]) << (FB - t);
      assign ge  = r_ff[t] >= dsh;

      always_ff @(posedge clock) begin
         r_ff[t+1]   <= ge ? r_ff[t] - dsh : r_ff[t];
         q_ff[t+1]   <= q_ff[t] | ((FB+1)'(ge) << (FB - t));
         f_ff[t+1]   <= f_ff[t];
         neg_ff[t+1] <= neg_ff[t];
      end
   end

   assign scaled = neg_ff[NS-1] ? -$signed({1'b0, q_ff[NS-1]}) : $signed({1'b0, q_ff[NS-1]});
endmodule

// ===== rtl/jpi_det.sv =====
// Determinant of the scaled matrix, its squared magnitude and adj * conj(det).
module jpi_det #(
   parameter int PART_WIDTH = jpi_pkg::DEFAULT_PART_WIDTH
) (
   input  logic                                   clock,
   input  logic signed [PART_WIDTH/2+1:0]         n_part [jpi_pkg::NUM_PARTS],
   output logic signed [3*(PART_WIDTH/2)+6:0]     x_part [jpi_pkg::NUM_PARTS],
   output logic        [4*(PART_WIDTH/2)+5:0]     q,
   output logic                                   det_zero
);
   import jpi_pkg::*;

   localparam int FB = PART_WIDTH / 2;
   localparam int NN = FB + 2;
   localparam int DW = 2 * NN;
   localparam int QW = 2 * DW - 2;
   localparam int AW = NN + DW;
   localparam int XW = AW + 1;

   logic signed [DW-1:0] pr_in   [8];
   logic signed [DW-1:0] pr_ff   [8];
   logic signed [NN-1:0] adj_in  [NUM_PARTS];
   logic signed [NN-1:0] adj1_ff [NUM_PARTS];
   logic signed [NN-1:0] adj2_ff [NUM_PARTS];
   logic signed [DW-1:0] dre_ff;
   logic signed [DW-1:0] dim_ff;
   logic signed [2*DW-1:0] sqr_full;
   logic signed [2*DW-1:0] sqi_full;
   logic [QW-1:0]        sqr_ff;
   logic [QW-1:0]        sqi_ff;
   logic signed [AW-1:0] ap_in [NUM_ELEMS][4];
   logic signed [AW-1:0] ap_ff [NUM_ELEMS][4];
   logic                 dz_ff;
   logic signed [XW-1:0] x_in [NUM_PARTS];
   logic signed [XW-1:0] x_ff [NUM_PARTS];
   logic [QW-1:0]        q_ff;
   logic                 dz2_ff;

   // Stage 1: cross products and the adjugate
   always_comb begin
      pr_in[0] = n_part[0] * n_part[6];
      pr_in[1] = n_part[1] * n_part[7];
      pr_in[2] = n_part[2] * n_part[4];
      pr_in[3] = n_part[3] * n_part[5];
      pr_in[4] = n_part[0] * n_part[7];
      pr_in[5] = n_part[1] * n_part[6];
      pr_in[6] = n_part[2] * n_part[5];
      pr_in[7] = n_part[3] * n_part[4];
      adj_in[0] = n_part[6];
      adj_in[1] = n_part[7];
      adj_in[2] = -n_part[2];
      adj_in[3] = -n_part[3];
      adj_in[4] = -n_part[4];
      adj_in[5] = -n_part[5];
      adj_in[6] = n_part[0];
      adj_in[7] = n_part[1];
   end

   always_ff @(posedge clock) begin
      pr_ff   <= pr_in;
      adj1_ff <= adj_in;
   end

   // Stage 2: determinant
   always_ff @(posedge clock) begin
      dre_ff  <= (pr_ff[0] - pr_ff[1]) - (pr_ff[2] - pr_ff[3]);
      dim_ff  <= (pr_ff[4] + pr_ff[5]) - (pr_ff[6] + pr_ff[7]);
      adj2_ff <= adj1_ff;
   end

   // Stage 3: squared magnitude terms and adj * det products
   assign sqr_full = dre_ff * dre_ff;
   assign sqi_full = dim_ff * dim_ff;

   always_comb begin
      for (int e = 0; e < NUM_ELEMS; e++) begin
         ap_in[e][0] = adj2_ff[2*e]   * dre_ff;
         ap_in[e][1] = adj2_ff[2*e+1] * dim_ff;
         ap_in[e][2] = adj2_ff[2*e+1] * dre_ff;
         ap_in[e][3] = adj2_ff[2*e]   * dim_ff;
      end
   end

   always_ff @(posedge clock) begin
      sqr_ff <= sqr_full[QW-1:0];
      sqi_ff <= sqi_full[QW-1:0];
      ap_ff  <= ap_in;
      dz_ff  <= (dre_ff == '0) && (dim_ff == '0);
   end

   // Stage 4: |det|^2 and adj * conj(det)
   always_comb begin
      logic signed [XW-1:0] a;
      logic signed [XW-1:0] b;
      for (int e = 0; e < NUM_ELEMS; e++) begin
         a          = ap_ff[e][0];
         b          = ap_ff[e][1];
         x_in[2*e]  = a + b;
         a          = ap_ff[e][2];
         b          = ap_ff[e][3];
         x_in[2*e+1] = a - b;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      q_ff   <= sqr_ff + sqi_ff;
      dz2_ff <= dz_ff;
   end

   assign x_part   = x_ff;
   assign q        = q_ff;
   assign det_zero = dz2_ff;
endmodule

// ===== rtl/jpi_inv_lane.sv =====
// One lane of the final divide: round(x * 2^(2FB) / q), clipped to a part.
module jpi_inv_lane #(
   parameter int PART_WIDTH = jpi_pkg::DEFAULT_PART_WIDTH
) (
   input  logic                                 clock,
   input  logic signed [3*(PART_WIDTH/2)+6:0]   x,
   input  logic        [4*(PART_WIDTH/2)+5:0]   q,
   output logic signed [PART_WIDTH-1:0]         part,
   output logic                                 sat
);
   localparam int FB = PART_WIDTH / 2;
   localparam int QW = 4 * FB + 6;
   localparam int XW = 3 * FB + 7;
   localparam int WD = QW + PART_WIDTH + 1;
   localparam int NS = PART_WIDTH + 2;

   logic [XW-1:0]         mag;
   logic [WD-1:0]         r_ff   [NS];
   logic [QW-1:0]         d_ff   [NS];
   logic [PART_WIDTH-1:0] qt_ff  [NS];
   logic                  neg_ff [NS];
   logic                  ov_ff  [NS];
   logic [PART_WIDTH-1:0] lim;
   logic [PART_WIDTH-1:0] val;
   logic                  big;

   // Setup: numerator with half-divisor rounding offset
   assign mag = x[XW-1] ? XW'(-x) : XW'(x);

   always_ff @(posedge clock) begin
      r_ff[0]   <= (WD'(mag) << (2 * FB)) + WD'(q >> 1);
      d_ff[0]   <= q;
      qt_ff[0]  <= '0;
      neg_ff[0] <= x[XW-1];
      ov_ff[0]  <= 1'b0;
   end

   // Quotient too large for a part at all
   always_ff @(posedge clock) begin
      r_ff[1]   <= r_ff[0];
      d_ff[1]   <= d_ff[0];
      qt_ff[1]  <= '0;
      neg_ff[1] <= neg_ff[0];
      ov_ff[1]  <= r_ff[0] >= (WD'(d_ff[0]) << PART_WIDTH);
   end

   // One quotient bit per stage
   for (genvar t = 0; t < PART_WIDTH; t++) begin : g_div
      logic [WD-1:0] dsh;
      logic          ge;

      assign dsh = WD'(d_ff[t+1]) << (PART_WIDTH - 1 - t);
      assign ge  = r_ff[t+1] >= dsh;

      always_ff @(posedge clock) begin
         r_ff[t+2]   <= ge ? r_ff[t+1] - dsh : r_ff[t+1];
         qt_ff[t+2]  <= qt_ff[t+1] | (PART_WIDTH'(ge) << (PART_WIDTH - 1 - t));
         d_ff[t+2]   <= d_ff[t+1];
         neg_ff[t+2] <= neg_ff[t+1];
         ov_ff[t+2]  <= ov_ff[t+1];
      end
   end

   // Clip to the part range and restore the sign
   always_comb begin
      lim  = neg_ff[NS-1] ? (PART_WIDTH'(1) << (PART_WIDTH - 1))
                          : (PART_WIDTH'(1) << (PART_WIDTH - 1)) - PART_WIDTH'(1);
      big  = ov_ff[NS-1] || (qt_ff[NS-1] > lim);
      val  = big ? lim : qt_ff[NS-1];
      part = neg_ff[NS-1] ? -$signed(val) : $signed(val);
      sat  = big;
   end
endmodule

// ===== rtl/jones_product_inverse_2x2_top.sv =====
// Top level: Jones product D*B, norm scaling and 2x2 complex inverse.
// Throughput: one word per cycle; the square-root and divider lanes retire one
// bit per pipeline stage, which sets the depth but not the rate.
// busy is high only during reset; results appear for one cycle, no output stall.
// Synchronous reset clears all valid and strobe state; datapath registers are not reset.
module jones_product_inverse_2x2_top #(
   parameter int PART_WIDTH = jpi_pkg::DEFAULT_PART_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_d_00,
   input  logic [63:0] req_d_01,
   input  logic [63:0] req_d_10,
   input  logic [63:0] req_d_11,
   input  logic [63:0] req_b_00,
   input  logic [63:0] req_b_01,
   input  logic [63:0] req_b_10,
   input  logic [63:0] req_b_11,
   output logic        rsp_strobe,
   output logic [63:0] rsp_inv_00,
   output logic [63:0] rsp_inv_01,
   output logic [63:0] rsp_inv_10,
   output logic [63:0] rsp_inv_11,
   output logic        rsp_all_zero,
   output logic        rsp_singular,
   output logic        rsp_saturated
);
   import jpi_pkg::*;

   localparam int FB = PART_WIDTH / 2;
   localparam int NN = FB + 2;
   localparam int QW = 4 * FB + 6;
   localparam int XW = 3 * FB + 7;
   localparam int LF = (FB + 2) + 4 + (PART_WIDTH + 2);
   localparam int LZ = PART_WIDTH + 2;

   logic [WORD_WIDTH-1:0]        d_word [NUM_ELEMS];
   logic [WORD_WIDTH-1:0]        b_word [NUM_ELEMS];
   logic signed [PART_WIDTH-1:0] d_part [NUM_PARTS];
   logic signed [PART_WIDTH-1:0] b_part [NUM_PARTS];
   logic                         in_valid;
   logic signed [PART_WIDTH-1:0] j_part [NUM_PARTS];
   flags_type                    j_flags;
   logic        [PART_WIDTH:0]   norm;
   logic signed [PART_WIDTH-1:0] jn_part [NUM_PARTS];
   flags_type                    n_flags;
   logic signed [NN-1:0]         s_part [NUM_PARTS];
   logic signed [XW-1:0]         x_part [NUM_PARTS];
   logic [QW-1:0]                q;
   logic                         det_zero;
   logic signed [PART_WIDTH-1:0] inv_part [NUM_PARTS];
   logic                         inv_sat [NUM_PARTS];
   flags_type                    fl_ff [LF];
   logic                         dz_ff [LZ];
   logic [WORD_WIDTH-1:0]        inv_in [NUM_ELEMS];
   logic [WORD_WIDTH-1:0]        inv_ff [NUM_ELEMS];
   logic                         strobe_in, strobe_ff;
   logic                         zero_in, zero_ff;
   logic                         sing_in, sing_ff;
   logic                         sat_in, sat_ff;

   // Input word unpacking
   assign busy     = reset;
   assign in_valid = start && !busy;
   assign d_word[0] = req_d_00;
   assign d_word[1] = req_d_01;
   assign d_word[2] = req_d_10;
   assign d_word[3] = req_d_11;
   assign b_word[0] = req_b_00;
   assign b_word[1] = req_b_01;
   assign b_word[2] = req_b_10;
   assign b_word[3] = req_b_11;

   always_comb begin
      for (int e = 0; e < NUM_ELEMS; e++) begin
         d_part[2*e]   = d_word[e][REAL_LSB +: PART_WIDTH];
         d_part[2*e+1] = d_word[e][IMAG_LSB +: PART_WIDTH];
         b_part[2*e]   = b_word[e][REAL_LSB +: PART_WIDTH];
         b_part[2*e+1] = b_word[e][IMAG_LSB +: PART_WIDTH];
      end
   end

   jpi_product #(.PART_WIDTH(PART_WIDTH)) u_product (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid),
      .d_part   (d_part),
      .b_part   (b_part),
      .j_part   (j_part),
      .j_flags  (j_flags)
   );

   jpi_norm #(.PART_WIDTH(PART_WIDTH)) u_norm (
      .clock     (clock),
      .reset     (reset),
      .j_part    (j_part),
      .in_flags  (j_flags),
      .norm      (norm),
      .j_out     (jn_part),
      .out_flags (n_flags)
   );

   // Eight scaling lanes, one per part
   for (genvar k = 0; k < NUM_PARTS; k++) begin : g_scale
      jpi_scale_lane #(.PART_WIDTH(PART_WIDTH)) u_scale (
         .clock  (clock),
         .part   (jn_part[k]),
         .norm   (norm),
         .scaled (s_part[k])
      );
   end

   jpi_det #(.PART_WIDTH(PART_WIDTH)) u_det (
      .clock    (clock),
      .n_part   (s_part),
      .x_part   (x_part),
      .q        (q),
      .det_zero (det_zero)
   );

   // Eight divide lanes, one per result part
   for (genvar k = 0; k < NUM_PARTS; k++) begin : g_inv
      jpi_inv_lane #(.PART_WIDTH(PART_WIDTH)) u_inv (
         .clock (clock),
         .x     (x_part[k]),
         .q     (q),
         .part  (inv_part[k]),
         .sat   (inv_sat[k])
      );
   end

   // Status delay lines matched to the lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LF; i++) begin
            fl_ff[i] <= '0;
         end
      end else begin
         fl_ff[0] <= n_flags;
         for (int i = 1; i < LF; i++) begin
            fl_ff[i] <= fl_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      dz_ff[0] <= det_zero;
      for (int i = 1; i < LZ; i++) begin
         dz_ff[i] <= dz_ff[i-1];
      end
   end

   // Merge lanes and flags into the result word
   always_comb begin
      logic kill;
      logic any_sat;
      kill    = fl_ff[LF-1].all_zero || dz_ff[LZ-1];
      any_sat = 1'b0;
      for (int k = 0; k < NUM_PARTS; k++) begin
         any_sat = any_sat | inv_sat[k];
      end
      for (int e = 0; e < NUM_ELEMS; e++) begin
         inv_in[e] = kill ? '0
                   : (WORD_WIDTH'(unsigned'(inv_part[2*e])) << REAL_LSB)
                   | (WORD_WIDTH'(unsigned'(inv_part[2*e+1])) << IMAG_LSB);
      end
      strobe_in = fl_ff[LF-1].valid;
      zero_in   = fl_ff[LF-1].all_zero;
      sing_in   = !fl_ff[LF-1].all_zero && dz_ff[LZ-1];
      if (fl_ff[LF-1].all_zero) begin
         sat_in = 1'b0;
      end else if (dz_ff[LZ-1]) begin
         sat_in = fl_ff[LF-1].sat;
      end else begin
         sat_in = fl_ff[LF-1].sat | any_sat;
      end
   end

   always_ff @(posedge clock) begin
      inv_ff  <= inv_in;
      zero_ff <= zero_in;
      sing_ff <= sing_in;
      sat_ff  <= sat_in;
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_inv_00    = inv_ff[0];
   assign rsp_inv_01    = inv_ff[1];
   assign rsp_inv_10    = inv_ff[2];
   assign rsp_inv_11    = inv_ff[3];
   assign rsp_all_zero  = zero_ff;
   assign rsp_singular  = sing_ff;
   assign rsp_saturated = sat_ff;
endmodule

// ===== rtl/jpi_checker.sv =====
// Port-level assertions for the Jones product inverse top, with its bind.
module jpi_checker #(
   parameter int PART_WIDTH = jpi_pkg::DEFAULT_PART_WIDTH
) (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [63:0] rsp_inv_00,
   input logic [63:0] rsp_inv_01,
   input logic [63:0] rsp_inv_10,
   input logic [63:0] rsp_inv_11,
   input logic        rsp_all_zero,
   input logic        rsp_singular,
   input logic        rsp_saturated
);
   localparam int LAT = 2 * PART_WIDTH + PART_WIDTH / 2 + 14;

   // Every accepted word yields a result
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_strobe)
      else $error("result missing after accepted word");

   // No result without a matching accepted word
   a_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LAT))
      else $error("result without accepted word");

   // Zero product and zero determinant are exclusive
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_all_zero && rsp_singular))
      else $error("all_zero and singular both set");

   // Degenerate cases give an all-zero inverse, zero product never saturates
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_all_zero || rsp_singular)) |->
      (rsp_inv_00 == 64'd0 && rsp_inv_01 == 64'd0 && rsp_inv_10 == 64'd0 &&
       rsp_inv_11 == 64'd0 && !(rsp_all_zero && rsp_saturated)))
      else $error("degenerate result not cleared");
endmodule

bind jones_product_inverse_2x2_top jpi_checker #(.PART_WIDTH(PART_WIDTH)) u_jpi_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_inv_00    (rsp_inv_00),
   .rsp_inv_01    (rsp_inv_01),
   .rsp_inv_10    (rsp_inv_10),
   .rsp_inv_11    (rsp_inv_11),
   .rsp_all_zero  (rsp_all_zero),
   .rsp_singular  (rsp_singular),
   .rsp_saturated (rsp_saturated)
);

// ===== sim/testbench.sv =====
// Testbench for the Jones product inverse block: directed table, then random words.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = jpi_pkg::DEFAULT_PART_WIDTH / 2;
   localparam int LIMIT_CYCLES = 400000;
   localparam int RANDOM_WORDS = 450;
   localparam int DRAIN_CYCLES = 150;
   localparam logic [63:0] ONE_RE = 64'h0001_0000_0000_0000;

   typedef struct packed {
      logic [3:0][63:0] inv;
      logic             all_zero;
      logic             singular;
      logic             saturated;
   } jones_result_type;

   typedef struct {
      logic [7:0][63:0] w;
      bit               typed;
      jones_result_type res;
   } table_row_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic [7:0][63:0] req_word;
   logic             rsp_strobe;
   logic [63:0]      rsp_inv_00, rsp_inv_01, rsp_inv_10, rsp_inv_11;
   logic             rsp_all_zero, rsp_singular, rsp_saturated;

   jones_result_type pending_inverses[$];
   table_row_type    stim_table[$];
   jones_result_type forced_result;
   bit               forced_valid;
   int               n_accepted = 0;
   int               n_errors = 0;
   int               cycle_count = 0;

   jones_product_inverse_2x2_top u_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_d_00     (req_word[0]),
      .req_d_01     (req_word[1]),
      .req_d_10     (req_word[2]),
      .req_d_11     (req_word[3]),
      .req_b_00     (req_word[4]),
      .req_b_01     (req_word[5]),
      .req_b_10     (req_word[6]),
      .req_b_11     (req_word[7]),
      .rsp_strobe   (rsp_strobe),
      .rsp_inv_00   (rsp_inv_00),
      .rsp_inv_01   (rsp_inv_01),
      .rsp_inv_10   (rsp_inv_10),
      .rsp_inv_11   (rsp_inv_11),
      .rsp_all_zero (rsp_all_zero),
      .rsp_singular (rsp_singular),
      .rsp_saturated(rsp_saturated)
   );

   // 10 ns clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Clip a magnitude to the part range, return the signed part
   function automatic logic signed [127:0] clip_part(input bit neg,
                                                     input logic signed [127:0] m,
                                                     inout bit sat);
      logic signed [127:0] limit;
      logic signed [127:0] v;
      limit = neg ? 128'sd2147483648 : 128'sd2147483647;
      v = m;
      if (v > limit) begin
         v = limit;
         sat = 1'b1;
      end
      return neg ? -v : v;
   endfunction

   // Drop FRAC fraction bits, round half away from zero, then clip
   function automatic logic signed [127:0] round_part(input logic signed [127:0] v,
                                                      inout bit sat);
      logic signed [127:0] m;
      m = (v < 0) ? -v : v;
      m = (m + 128'sd32768) >>> FRAC;
      return clip_part(v < 0, m, sat);
   endfunction

   // Rounded quotient x * 2^(2*FRAC) / q, clipped
   function automatic logic signed [127:0] divide_part(input logic signed [127:0] x,
                                                       input logic signed [127:0] q,
                                                       inout bit sat);
      logic signed [127:0] m;
      m = (((x < 0) ? -x : x) << (2 * FRAC)) + (q >>> 1);
      m = m / q;
      return clip_part(x < 0, m, sat);
   endfunction

   // Expected inverse of the norm-scaled product D*B
   function automatic jones_result_type predict_inverse(input logic [7:0][63:0] w);
      logic signed [127:0] dre[4], dim[4], bre[4], bim[4];
      logic signed [127:0] jre[4], jim[4], nre[4], nim[4], are[4], aim[4];
      logic signed [127:0] acc, norm, f, t, det_re, det_im, q, xr, xi, zr, zi, m;
      bit                  sat;
      bit                  nonzero;
      jones_result_type    r;
      int                  i, rr, cc, k;
      sat = 1'b0;
      nonzero = 1'b0;
      r = '0;
      for (i = 0; i < 4; i++) begin
         dre[i] = $signed(w[i][63:32]);
         dim[i] = $signed(w[i][31:0]);
         bre[i] = $signed(w[4+i][63:32]);
         bim[i] = $signed(w[4+i][31:0]);
      end
      // product J = D*B
      for (rr = 0; rr < 2; rr++) begin
         for (cc = 0; cc < 2; cc++) begin
            acc = dre[2*rr] * bre[cc] - dim[2*rr] * bim[cc]
                + dre[2*rr+1] * bre[2+cc] - dim[2*rr+1] * bim[2+cc];
            jre[2*rr+cc] = round_part(acc, sat);
            acc = dre[2*rr] * bim[cc] + dim[2*rr] * bre[cc]
                + dre[2*rr+1] * bim[2+cc] + dim[2*rr+1] * bre[2+cc];
            jim[2*rr+cc] = round_part(acc, sat);
         end
      end
      for (i = 0; i < 4; i++)
         if (jre[i] != 0 || jim[i] != 0) nonzero = 1'b1;
      if (!nonzero) begin
         r.all_zero = 1'b1;
         return r;
      end
      // Frobenius norm, floor of the square root
      norm = 0;
      for (i = 0; i < 4; i++) norm = norm + jre[i] * jre[i] + jim[i] * jim[i];
      f = 0;
      for (k = 34; k >= 0; k--) begin
         t = f | (128'sd1 << k);
         if (t * t <= norm) f = t;
      end
      // scale by the norm
      for (i = 0; i < 4; i++) begin
         m = ((((jre[i] < 0) ? -jre[i] : jre[i]) << FRAC) + (f >>> 1)) / f;
         nre[i] = (jre[i] < 0) ? -m : m;
         m = ((((jim[i] < 0) ? -jim[i] : jim[i]) << FRAC) + (f >>> 1)) / f;
         nim[i] = (jim[i] < 0) ? -m : m;
      end
      det_re = (nre[0] * nre[3] - nim[0] * nim[3]) - (nre[1] * nre[2] - nim[1] * nim[2]);
      det_im = (nre[0] * nim[3] + nim[0] * nre[3]) - (nre[1] * nim[2] + nim[1] * nre[2]);
      if (det_re == 0 && det_im == 0) begin
         r.singular = 1'b1;
         r.saturated = sat;
         return r;
      end
      // adjugate times conj(det) over |det|^2
      q = det_re * det_re + det_im * det_im;
      are[0] = nre[3];  aim[0] = nim[3];
      are[1] = -nre[1]; aim[1] = -nim[1];
      are[2] = -nre[2]; aim[2] = -nim[2];
      are[3] = nre[0];  aim[3] = nim[0];
      for (i = 0; i < 4; i++) begin
         xr = are[i] * det_re + aim[i] * det_im;
         xi = aim[i] * det_re - are[i] * det_im;
         zr = divide_part(xr, q, sat);
         zi = divide_part(xi, q, sat);
         r.inv[i] = {zr[31:0], zi[31:0]};
      end
      r.saturated = sat;
      return r;
   endfunction

   // One packed complex element; kind 0 full random, 1 moderate, 2 zero
   function automatic logic [63:0] rand_elem(input int kind);
      int pre, pim;
      if (kind == 0) return {$urandom, $urandom};
      if (kind == 2) return 64'd0;
      pre = int'($urandom_range(0, 262144)) - 131072;
      pim = int'($urandom_range(0, 262144)) - 131072;
      return {pre, pim};
   endfunction

   task automatic add_row(input logic [7:0][63:0] w, input bit typed,
                          input jones_result_type res);
      table_row_type row;
      row.w = w;
      row.typed = typed;
      row.res = res;
      stim_table.push_back(row);
   endtask

   // Drive one word and wait for its acceptance
   task automatic send_word(input logic [7:0][63:0] w);
      int seen;
      seen = n_accepted;
      req_word <= w;
      start <= 1'b1;
      do @(negedge clock); while (n_accepted == seen);
   endtask

   // Random idle between words: mostly none, some short, few long
   task automatic idle_gap();
      int pick, gap;
      pick = $urandom_range(0, 99);
      if (pick < 60) gap = 0;
      else if (pick < 95) gap = $urandom_range(1, 4);
      else gap = $urandom_range(20, 200);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Accept words, predict, and check results at the rising edge
   always @(posedge clock) begin
      jones_result_type got, want;
      if (!reset && start && !busy) begin
         if (forced_valid) pending_inverses.push_back(forced_result);
         else pending_inverses.push_back(predict_inverse(req_word));
         n_accepted <= n_accepted + 1;
      end
      if (!reset && rsp_strobe) begin
         got.inv[0] = rsp_inv_00;
         got.inv[1] = rsp_inv_01;
         got.inv[2] = rsp_inv_10;
         got.inv[3] = rsp_inv_11;
         got.all_zero = rsp_all_zero;
         got.singular = rsp_singular;
         got.saturated = rsp_saturated;
         if (pending_inverses.size() == 0) begin
            $error("result word with nothing expected");
            n_errors++;
         end else begin
            want = pending_inverses.pop_front();
            for (int i = 0; i < 4; i++)
               if (got.inv[i] !== want.inv[i]) begin
                  $error("inv_%0d%0d: expected %h, got %h", i / 2, i % 2,
                         want.inv[i], got.inv[i]);
                  n_errors++;
               end
            if (got.all_zero !== want.all_zero) begin
               $error("all_zero: expected %b, got %b", want.all_zero, got.all_zero);
               n_errors++;
            end
            if (got.singular !== want.singular) begin
               $error("singular: expected %b, got %b", want.singular, got.singular);
               n_errors++;
            end
            if (got.saturated !== want.saturated) begin
               $error("saturated: expected %b, got %b", want.saturated, got.saturated);
               n_errors++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // Stimulus
   initial begin
      logic [7:0][63:0] w;
      jones_result_type res;
      int               pick;
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      forced_valid = 1'b0;
      forced_result = '0;

      // all-zero inputs: zero product
      res = '0; res.all_zero = 1'b1;
      add_row('0, 1'b1, res);
      // every part at -1 LSB: product rounds to zero
      add_row({8{64'hFFFF_FFFF_FFFF_FFFF}}, 1'b1, res);
      // zero D, random B
      w = '0;
      for (int i = 4; i < 8; i++) w[i] = rand_elem(0);
      add_row(w, 1'b1, res);
      // D = B = all ones (real 1.0): rank one product, zero determinant
      res = '0; res.singular = 1'b1;
      add_row({8{ONE_RE}}, 1'b1, res);
      // identities
      res = '0;
      add_row({ONE_RE, 64'd0, 64'd0, ONE_RE, ONE_RE, 64'd0, 64'd0, ONE_RE}, 1'b0, res);
      // diagonal D with 1.0 and 2.0, diagonal B with 0.5 and 1.0
      add_row({ONE_RE, 64'd0, 64'd0, 64'h0000_8000_0000_0000,
               64'h0002_0000_0000_0000, 64'd0, 64'd0, ONE_RE}, 1'b0, res);
      // extremes: all max, all min, mixed
      add_row({8{64'h7FFF_FFFF_7FFF_FFFF}}, 1'b0, res);
      add_row({8{64'h8000_0000_8000_0000}}, 1'b0, res);
      add_row({{4{64'h7FFF_FFFF_8000_0000}}, {4{64'h8000_0000_7FFF_FFFF}}}, 1'b0, res);
      add_row({64'h7FFF_FFFF_0000_0000, 64'd0, 64'd0, 64'h0000_0000_7FFF_FFFF,
               64'h8000_0000_0000_0000, 64'd0, 64'd0, 64'h8000_0000_0000_0000},
              1'b0, res);
      // tiny product next to a large one
      add_row({64'h0000_0001_0000_0000, 64'd0, 64'd0, 64'h0100_0000_0000_0000,
               ONE_RE, 64'd0, 64'd0, ONE_RE}, 1'b0, res);
      // equal rows in D: singular product
      w[0] = rand_elem(1); w[1] = rand_elem(1);
      w[2] = w[0]; w[3] = w[1];
      for (int i = 4; i < 8; i++) w[i] = rand_elem(1);
      add_row(w, 1'b0, res);
      for (int i = 0; i < 8; i++) w[i] = rand_elem(1);
      add_row(w, 1'b0, res);

      repeat (10) @(negedge clock);
      reset = 1'b0;
      while (busy) @(negedge clock);

      // directed table
      foreach (stim_table[i]) begin
         forced_valid <= stim_table[i].typed;
         forced_result <= stim_table[i].res;
         send_word(stim_table[i].w);
         idle_gap();
      end
      forced_valid <= 1'b0;
      start <= 1'b0;
      // hold off until the pipeline has drained
      while (pending_inverses.size() != 0) @(negedge clock);

      // random words
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         pick = $urandom_range(0, 99);
         for (int i = 0; i < 8; i++) w[i] = rand_elem(pick < 70 ? 1 : 0);
         if (pick >= 90 && pick < 94) begin
            for (int i = 0; i < 4; i++) w[i] = rand_elem(2);
         end else if (pick >= 94) begin
            // equal rows of B give a singular product
            w[6] = w[4];
            w[7] = w[5];
         end
         send_word(w);
         idle_gap();
      end
      start <= 1'b0;

      while (pending_inverses.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (n_errors == 0 && pending_inverses.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end
endmodule
